### rtl/color_lut_trilinear_macros.svh
// Assertion macros used by the checker file.
`ifndef COLOR_LUT_TRILINEAR_MACROS_SVH
`define COLOR_LUT_TRILINEAR_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define CLT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked at every clock edge outside reset.
`define CLT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Implication checked at every clock edge, reset included.
`define CLT_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error(msg);

`endif

### rtl/clt_pkg.sv
// Shared constants and helpers of the 3D color lookup block.
package clt_pkg;

    localparam int MAX_DIM_DEF = 16;
    localparam int PIX_W       = 8;
    localparam int IDX_W       = 12;
    localparam int CFG_W       = 5;
    localparam int ENTRY_W     = 3 * PIX_W;
    localparam logic [CFG_W-1:0] DIM_RESET = 5'd16;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    // floor(x / 255) for x below 65280, without a divider
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] s;
        s = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
        return s[15:8];
    endfunction

endpackage

### rtl/clt_stream_if.sv
// Valid/ready channels: pixel or load input, and interpolated color output.
interface clt_in_if
    import clt_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             opcode;
    logic [IDX_W-1:0] entry_index;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;

    modport source (output valid, opcode, entry_index, red, green, blue, input ready);
    modport sink   (input valid, opcode, entry_index, red, green, blue, output ready);
endinterface

interface clt_out_if
    import clt_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] out_red;
    logic [PIX_W-1:0] out_green;
    logic [PIX_W-1:0] out_blue;

    modport source (output valid, out_red, out_green, out_blue, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, output ready);
endinterface

### rtl/color_lut_trilinear.sv
// Top level: 3D color lookup table with trilinear blend, eight-stage pipeline.
//
//  channel   dir  handshake      beat
//  i_pix     in   valid/ready    opcode, entry_index, red, green, blue
//  o_pix     out  valid/ready    out_red, out_green, out_blue
//  i_cfg_*   in   write enable   lut_dim (5 bits)
//
// One beat per cycle unless o_pix stalls; results leave from the output register.
// The table is held in eight copies so all eight corners read in the same cycle.
// Loads write all copies at stage 5 and give no output beat.
// Backpressure on o_pix freezes the whole pipe; i_pix.ready drops with it.
// Reset clears valid bits and sets lut_dim to 16; table contents are undefined.
module color_lut_trilinear
    import clt_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    clt_in_if.sink           i_pix,
    clt_out_if.source        o_pix
);

    localparam int DW    = $clog2(MAX_DIM + 1);
    localparam int CW    = $clog2(MAX_DIM);
    localparam int TW    = $clog2(MAX_DIM * MAX_DIM);
    localparam int DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = PIX_W + CW;

    // config register and effective dimension
    logic [CFG_W-1:0] r_lut_dim;
    logic [DW-1:0]    eff_dim;
    logic [CW-1:0]    dm1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lut_dim <= DIM_RESET;
        end else if (i_cfg_we) begin
            r_lut_dim <= i_cfg_wdata;
        end
    end

    always_comb begin
        if (int'(r_lut_dim) < 2) begin
            eff_dim = DW'(2);
        end else if (int'(r_lut_dim) > MAX_DIM) begin
            eff_dim = DW'(MAX_DIM);
        end else begin
            eff_dim = DW'(r_lut_dim);
        end
        dm1 = CW'(eff_dim - DW'(1));
    end

    // global advance: pipe moves unless the output beat is stuck
    logic adv;
    logic r_o_v;
    assign adv         = !r_o_v || o_pix.ready;
    assign i_pix.ready = adv;

    logic [PIX_W-1:0] in_ch [3];
    assign in_ch[0] = i_pix.red;
    assign in_ch[1] = i_pix.green;
    assign in_ch[2] = i_pix.blue;

    // valid bits, per stage
    logic r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_s5_v, r_s6_v, r_s7_v;
    logic r_s1_op, r_s2_op, r_s3_op, r_s4_op;

    // load payload traveling to the memory stage
    logic [IDX_W-1:0]   r_s1_wa, r_s2_wa, r_s3_wa, r_s4_wa;
    logic [ENTRY_W-1:0] r_s1_wd, r_s2_wd, r_s3_wd, r_s4_wd;

    // grid position datapath
    logic [PW-1:0]    r_s1_p  [3];
    logic [CW-1:0]    r_s2_lo [3];
    logic [CW-1:0]    r_s2_hi [3];
    logic [PIX_W-1:0] r_s2_f  [3];
    logic [PIX_W-1:0] r_s3_f  [3];
    logic [PIX_W-1:0] r_s4_f  [3];
    logic [PIX_W-1:0] r_s5_f  [3];
    logic [PIX_W-1:0] r_s6_f  [3];
    logic [PIX_W-1:0] r_s7_f  [3];
    logic [CW-1:0]    r_s3_rc [2];
    logic [TW-1:0]    r_s3_t  [4];
    logic [AW-1:0]    r_s4_a  [8];
    logic [ENTRY_W-1:0] r_s5_e [8];
    logic [15:0]      r_s6_x  [4][3];
    logic [23:0]      r_s7_y  [2][3];
    logic [PIX_W-1:0] r_o_c   [3];

    // stage 2 combinational: cell index, fraction, upper corner
    logic [CW-1:0]    n_lo [3];
    logic [CW-1:0]    n_hi [3];
    logic [PIX_W-1:0] n_f  [3];

    always_comb begin
        logic [7:0]  q;
        logic [7:0]  rem;
        logic [15:0] p16;
        for (int c = 0; c < 3; c++) begin
            p16     = 16'(r_s1_p[c]);
            q       = div255(p16);
            rem     = 8'(p16 - 16'(q) * 16'd255);
            n_f[c]  = div255({rem, 8'b0});
            n_lo[c] = CW'(q);
            n_hi[c] = (n_lo[c] == dm1) ? n_lo[c] : n_lo[c] + CW'(1);
        end
    end

    // control: valid bits under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0; r_s2_v <= 1'b0; r_s3_v <= 1'b0; r_s4_v <= 1'b0;
            r_s5_v <= 1'b0; r_s6_v <= 1'b0; r_s7_v <= 1'b0; r_o_v  <= 1'b0;
        end else if (adv) begin
            r_s1_v <= i_pix.valid;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
            // loads end at the memory stage
            r_s5_v <= r_s4_v && (r_s4_op == OP_PIXEL);
            r_s6_v <= r_s5_v;
            r_s7_v <= r_s6_v;
            r_o_v  <= r_s7_v;
        end
    end

    // datapath stages 1-4: scale, split, address
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_op <= i_pix.opcode;
            r_s1_wa <= i_pix.entry_index;
            r_s1_wd <= {i_pix.blue, i_pix.green, i_pix.red};
            for (int c = 0; c < 3; c++) begin
                r_s1_p[c] <= PW'(in_ch[c]) * PW'(dm1);
            end

            r_s2_op <= r_s1_op;
            r_s2_wa <= r_s1_wa;
            r_s2_wd <= r_s1_wd;
            r_s2_lo <= n_lo;
            r_s2_hi <= n_hi;
            r_s2_f  <= n_f;

            // partial address g + dim*b for each (g,b) corner
            r_s3_op <= r_s2_op;
            r_s3_wa <= r_s2_wa;
            r_s3_wd <= r_s2_wd;
            r_s3_f  <= r_s2_f;
            r_s3_rc[0] <= r_s2_lo[0];
            r_s3_rc[1] <= r_s2_hi[0];
            for (int gi = 0; gi < 2; gi++) begin
                for (int bi = 0; bi < 2; bi++) begin
                    r_s3_t[gi*2+bi] <= TW'(gi == 1 ? r_s2_hi[1] : r_s2_lo[1])
                        + TW'(eff_dim) * TW'(bi == 1 ? r_s2_hi[2] : r_s2_lo[2]);
                end
            end

            // full address r + dim*t for each of the eight corners
            r_s4_op <= r_s3_op;
            r_s4_wa <= r_s3_wa;
            r_s4_wd <= r_s3_wd;
            r_s4_f  <= r_s3_f;
            for (int ri = 0; ri < 2; ri++) begin
                for (int k = 0; k < 4; k++) begin
                    r_s4_a[ri*4+k] <= AW'(r_s3_rc[ri]) + AW'(eff_dim) * AW'(r_s3_t[k]);
                end
            end
        end
    end

    // eight table copies: common write, one corner read each
    logic load_we;
    assign load_we = adv && r_s4_v && (r_s4_op == OP_LOAD) && (int'(r_s4_wa) < DEPTH);

    for (genvar k = 0; k < 8; k++) begin : g_bank
        logic [ENTRY_W-1:0] mem [DEPTH];
        always_ff @(posedge i_clk) begin
            if (load_we) begin
                mem[AW'(r_s4_wa)] <= r_s4_wd;
            end
            if (adv) begin
                r_s5_e[k] <= mem[r_s4_a[k]];
            end
        end
    end

    // stages 6-8: blend along b, then g, then r
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s5_f <= r_s4_f;

            r_s6_f <= r_s5_f;
            for (int k2 = 0; k2 < 4; k2++) begin
                for (int c = 0; c < 3; c++) begin
                    r_s6_x[k2][c] <= 16'(r_s5_e[k2*2][8*c +: 8]) * 16'(9'd256 - 9'(r_s5_f[2]))
                        + 16'(r_s5_e[k2*2+1][8*c +: 8]) * 16'(r_s5_f[2]);
                end
            end

            r_s7_f <= r_s6_f;
            for (int ri = 0; ri < 2; ri++) begin
                for (int c = 0; c < 3; c++) begin
                    r_s7_y[ri][c] <= 24'(r_s6_x[ri*2][c]) * 24'(9'd256 - 9'(r_s6_f[1]))
                        + 24'(r_s6_x[ri*2+1][c]) * 24'(r_s6_f[1]);
                end
            end

            for (int c = 0; c < 3; c++) begin
                r_o_c[c] <= 8'((32'(r_s7_y[0][c]) * 32'(9'd256 - 9'(r_s7_f[0]))
                    + 32'(r_s7_y[1][c]) * 32'(r_s7_f[0])) >> 24);
            end
        end
    end

    assign o_pix.valid     = r_o_v;
    assign o_pix.out_red   = r_o_c[0];
    assign o_pix.out_green = r_o_c[1];
    assign o_pix.out_blue  = r_o_c[2];

endmodule

### rtl/clt_checker.sv
// Port-level checker for the 3D color lookup block, bound to the top level.
`include "color_lut_trilinear_macros.svh"

module clt_checker
    import clt_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [PIX_W-1:0] i_out_red,
    input logic [PIX_W-1:0] i_out_green,
    input logic [PIX_W-1:0] i_out_blue
);

    // a stalled output beat stays and holds its payload
    `CLT_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "output beat dropped while stalled")
    `CLT_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_red) && $stable(i_out_green) && $stable(i_out_blue), "output payload changed while stalled")
    // input is refused only under output backpressure
    `CLT_ASSERT_IMP(a_ready, i_clk, i_rst_n, !i_in_ready, i_out_valid && !i_out_ready, "input stalled without output backpressure")
    // nothing comes out right after reset
    `CLT_ASSERT_ALWAYS(a_rst, i_clk, !$past(i_rst_n), !i_out_valid, "output beat right after reset")

endmodule

bind color_lut_trilinear clt_checker u_clt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_out_red   (o_pix.out_red),
    .i_out_green (o_pix.out_green),
    .i_out_blue  (o_pix.out_blue)
);
